@@ rtl/core/psg_pkg.sv @@
// Shared types and constants for the sound generator core.
// No dependencies; imported by every module under rtl/core.
`default_nettype none
package psg_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [7:0] PORT_LO = 8'h7E;
  localparam logic [7:0] PORT_HI = 8'h7F;

  localparam logic [3:0] ATTEN_SILENT = 4'hF;

  // channel index of the noise generator in the latch select field
  localparam logic [1:0] NOISE_CHAN = 2'd3;

  // noise rate codes (low two bits of noise control)
  localparam logic [1:0] NOISE_RATE_16  = 2'd0;
  localparam logic [1:0] NOISE_RATE_32  = 2'd1;
  localparam logic [1:0] NOISE_RATE_64  = 2'd2;
  localparam logic [1:0] NOISE_RATE_T2  = 2'd3;

  localparam logic [6:0] NOISE_RELOAD_16 = 7'h10;
  localparam logic [6:0] NOISE_RELOAD_32 = 7'h20;
  localparam logic [6:0] NOISE_RELOAD_64 = 7'h40;

  localparam int NUM_TONES = 3;
  localparam int NUM_CHANS = 4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] port;
    logic [7:0] data_byte;
  } psg_in_t;

  typedef struct packed {
    logic       tone0_level;
    logic       tone1_level;
    logic       tone2_level;
    logic [3:0] atten0;
    logic [3:0] atten1;
    logic [3:0] atten2;
    logic [3:0] atten3;
    logic       noise_shift;
  } psg_out_t;

endpackage
`default_nettype wire

@@ rtl/core/psg_reg_file.sv @@
// Register file: latch/data byte decode, tone periods, noise control, attenuation.
// Depends on psg_pkg.
`default_nettype none
module psg_reg_file #(
  parameter int PERIOD_WIDTH = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [7:0]              wr_byte,
  output logic [PERIOD_WIDTH-1:0]      tone_period [3],
  output logic [2:0]                   noise_ctrl,
  output logic [3:0]                   atten_next  [4]
);
  import psg_pkg::*;

  localparam logic [PERIOD_WIDTH-1:0] LO_MASK = PERIOD_WIDTH'(10'h00F);
  localparam logic [PERIOD_WIDTH-1:0] HI_MASK = PERIOD_WIDTH'(10'h3F0);

  logic [2:0]              latch_select, latch_select_next;
  logic [3:0]              attenuation [4];
  logic [PERIOD_WIDTH-1:0] tone_period_next [3];
  logic [2:0]              noise_ctrl_next;
  logic [1:0]              ch;
  logic                    is_att;
  logic                    is_latch;

  always_comb begin
    is_latch          = wr_byte[7];
    latch_select_next = latch_select;
    if (wr_en && is_latch) begin
      latch_select_next = wr_byte[6:4];
    end
    ch     = latch_select_next[2:1];
    is_att = latch_select_next[0];

    atten_next       = attenuation;
    tone_period_next = tone_period;
    noise_ctrl_next  = noise_ctrl;
    if (wr_en) begin
      if (is_att) begin
        atten_next[ch] = wr_byte[3:0];
      end else if (is_latch) begin
        if (ch != NOISE_CHAN) begin
          tone_period_next[ch] = (tone_period[ch] & ~LO_MASK) | PERIOD_WIDTH'(wr_byte[3:0]);
        end else begin
          noise_ctrl_next = wr_byte[2:0];
        end
      end else if (ch != NOISE_CHAN) begin
        // data byte fills period bits 9:4
        tone_period_next[ch] = (tone_period[ch] & ~HI_MASK)
                             | (PERIOD_WIDTH'(wr_byte[5:0]) << 4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_select <= '0;
      noise_ctrl   <= '0;
      for (int i = 0; i < NUM_TONES; i++) tone_period[i] <= '0;
      for (int i = 0; i < NUM_CHANS; i++) attenuation[i] <= ATTEN_SILENT;
    end else begin
      latch_select <= latch_select_next;
      noise_ctrl   <= noise_ctrl_next;
      tone_period  <= tone_period_next;
      attenuation  <= atten_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/psg_counters.sv @@
// Tone and noise down-counters with square levels and noise shift flag.
// Depends on psg_pkg; periods come from psg_reg_file.
`default_nettype none
module psg_counters #(
  parameter int PERIOD_WIDTH = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    tick,
  input  wire logic [PERIOD_WIDTH-1:0] tone_period [3],
  input  wire logic [2:0]              noise_ctrl,
  output logic                         level_next [3],
  output logic                         shift
);
  import psg_pkg::*;

  logic [PERIOD_WIDTH-1:0] cnt      [4];
  logic [PERIOD_WIDTH-1:0] cnt_next [4];
  logic [PERIOD_WIDTH-1:0] dec      [4];
  logic                    level    [3];
  logic [PERIOD_WIDTH-1:0] noise_reload;

  always_comb begin
    case (noise_ctrl[1:0])
      NOISE_RATE_16: noise_reload = PERIOD_WIDTH'(NOISE_RELOAD_16);
      NOISE_RATE_32: noise_reload = PERIOD_WIDTH'(NOISE_RELOAD_32);
      NOISE_RATE_64: noise_reload = PERIOD_WIDTH'(NOISE_RELOAD_64);
      NOISE_RATE_T2: noise_reload = tone_period[2];
      default:       noise_reload = tone_period[2];
    endcase
  end

  always_comb begin
    cnt_next   = cnt;
    level_next = level;
    shift      = 1'b0;
    for (int i = 0; i < NUM_CHANS; i++) begin
      dec[i] = (cnt[i] != '0) ? cnt[i] - PERIOD_WIDTH'(1) : '0;
    end
    if (tick) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        cnt_next[i] = dec[i];
        if (dec[i] == '0) begin
          cnt_next[i]   = (tone_period[i] != '0) ? tone_period[i] : PERIOD_WIDTH'(1);
          level_next[i] = ~level[i];
        end
      end
      cnt_next[3] = dec[3];
      if (dec[3] == '0) begin
        cnt_next[3] = noise_reload;
        shift       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANS; i++) cnt[i] <= '0;
      for (int i = 0; i < NUM_TONES; i++) level[i] <= 1'b1;
    end else begin
      cnt   <= cnt_next;
      level <= level_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/psg_register_and_tone_counters_unit.sv @@
// Sound generator core top: input register, register file, counters, result register.
// Beat held in in_q, result in out_data; one beat per cycle unless out_ready stalls.
// Throughput is set by the single state update stage between the two registers.
// Synchronous active-high rst: periods, counters and noise control zero,
// attenuation 15, tone levels high, latch select zero, both registers empty.
`default_nettype none
module psg_register_and_tone_counters_unit #(
  parameter int PERIOD_WIDTH = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire psg_pkg::psg_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output psg_pkg::psg_out_t     out_data
);
  import psg_pkg::*;

  psg_in_t                 in_q;
  logic                    in_q_valid;
  logic                    advance;
  logic                    wr_en;
  logic                    tick;
  logic [PERIOD_WIDTH-1:0] tone_period [3];
  logic [2:0]              noise_ctrl;
  logic [3:0]              atten_next  [4];
  logic                    level_next  [3];
  logic                    shift;
  psg_out_t                result;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;
  assign wr_en    = advance && (in_q.opcode == OP_WRITE)
                 && ((in_q.port == PORT_LO) || (in_q.port == PORT_HI));
  assign tick     = advance && (in_q.opcode == OP_TICK);

  psg_reg_file #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_regs (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_byte     (in_q.data_byte),
    .tone_period (tone_period),
    .noise_ctrl  (noise_ctrl),
    .atten_next  (atten_next)
  );

  psg_counters #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_cnt (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .tone_period (tone_period),
    .noise_ctrl  (noise_ctrl),
    .level_next  (level_next),
    .shift       (shift)
  );

  always_comb begin
    result.tone0_level = level_next[0];
    result.tone1_level = level_next[1];
    result.tone2_level = level_next[2];
    result.atten0      = atten_next[0];
    result.atten1      = atten_next[1];
    result.atten2      = atten_next[2];
    result.atten3      = atten_next[3];
    result.noise_shift = shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    // result beat holds until taken
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire
